>>> hw/rtl/go_to_goal_steering_assert.svh
// Assertion macros used by the steering top level.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef GO_TO_GOAL_STEERING_ASSERT_SVH
`define GO_TO_GOAL_STEERING_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define GGS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("go_to_goal_steering: assertion failed");
// next-cycle implication
`define GGS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("go_to_goal_steering: assertion failed");
`else
`define GGS_ASSERT_IMP(name, ante, cons)
`define GGS_ASSERT_NXT(name, ante, cons)
`endif

`endif

>>> hw/rtl/ggs_pkg.sv
// Shared types, widths and constants of the go-to-goal steering block.
// No dependencies; imported by every RTL module.
`timescale 1ns / 1ps
`default_nettype none

package ggs_pkg;

  // CORDIC datapath widths
  localparam int unsigned XY_W = 28;  // x, y scaled by 256, with gain headroom
  localparam int unsigned Z_W  = 24;  // angle accumulator, Q20 radians
  // square root datapath widths
  localparam int unsigned N_W  = 34;  // squared distance, padded to an even width
  localparam int unsigned Q_W  = 17;  // root
  localparam int unsigned R_W  = 18;  // partial remainder
  localparam int unsigned SQRT_DIGITS = N_W / 2;
  localparam int unsigned MAX_STEPS   = 24;

  localparam logic signed [Z_W-1:0] HALF_PI_Q20 = 24'sd1647099;
  // distance above 0.1 exactly when dx^2 + dy^2 > 10485
  localparam logic [N_W-1:0] NEAR_D2  = 34'd10485;
  // 0.2 rad in rad * 4096
  localparam logic [17:0]    TURN_LIM = 18'd819;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_TARGET_X  = 3'd0,
    CFG_TARGET_Y  = 3'd1,
    CFG_GAIN      = 3'd2,
    CFG_MAX_SPEED = 3'd3
  } cfg_idx_e;

  localparam logic signed [15:0] RST_TARGET_X  = 16'sd1024;
  localparam logic signed [15:0] RST_TARGET_Y  = 16'sd1024;
  localparam logic [11:0]        RST_GAIN      = 12'd256;
  localparam logic [15:0]        RST_MAX_SPEED = 16'd3072;

  typedef struct packed {
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic [11:0]        gain;
    logic [15:0]        max_speed;
  } cfg_t;

  // one item in flight through the cell row
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [N_W-1:0]         n;    // radicand, shifted up two bits per root digit
    logic [Q_W-1:0]         q;    // root so far
    logic [R_W-1:0]         r;    // remainder so far
    logic signed [14:0]     hd;   // measured heading
    logic                   far;  // outside the stop radius
  } item_t;

  // arctangent of 2^-i in Q20, rounded to nearest except index 21, which is rounded up
  function automatic logic signed [Z_W-1:0] atan_q20(input int unsigned idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0:  v = 24'sd823550;
      1:  v = 24'sd486170;
      2:  v = 24'sd256879;
      3:  v = 24'sd130396;
      4:  v = 24'sd65451;
      5:  v = 24'sd32757;
      6:  v = 24'sd16383;
      7:  v = 24'sd8192;
      8:  v = 24'sd4096;
      9:  v = 24'sd2048;
      10: v = 24'sd1024;
      11: v = 24'sd512;
      12: v = 24'sd256;
      13: v = 24'sd128;
      14: v = 24'sd64;
      15: v = 24'sd32;
      16: v = 24'sd16;
      17: v = 24'sd8;
      18: v = 24'sd4;
      19: v = 24'sd2;
      20: v = 24'sd1;
      21: v = 24'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/go_to_goal_steering.sv
// From input beat to result beat: min(CORDIC_STEPS, 24) cells but at least 17, plus
// 5 register stages. Every cell and stage is its own register slice.
// Throughput: one pose per cycle while the output is not stalled.
// A stalled output backs up through the row, filling bubbles before input stalls.
// Reset (async, active low) empties the pipeline and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "go_to_goal_steering_assert.svh"

module go_to_goal_steering #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  // pose input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [14:0] heading_i,
  // command output
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        linear_speed_o,
  output logic [14:0]        turn_rate_o
);
  import ggs_pkg::*;

  localparam int unsigned Steps = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam int unsigned NCell = (Steps > SQRT_DIGITS) ? Steps : SQRT_DIGITS;

  cfg_t cfg_q;

  logic  chain_v [NCell+1];
  logic  chain_r [NCell+1];
  item_t chain_d [NCell+1];
  logic  front_ready;

  // configuration registers; writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_x  <= RST_TARGET_X;
      cfg_q.target_y  <= RST_TARGET_Y;
      cfg_q.gain      <= RST_GAIN;
      cfg_q.max_speed <= RST_MAX_SPEED;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_TARGET_X:  cfg_q.target_x  <= cfg_data_i;
        CFG_TARGET_Y:  cfg_q.target_y  <= cfg_data_i;
        CFG_GAIN:      cfg_q.gain      <= cfg_data_i[11:0];
        CFG_MAX_SPEED: cfg_q.max_speed <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // offset, squares, fold
  ggs_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .valid_i   (in_valid_i),
    .ready_o   (front_ready),
    .pos_x_i   (pos_x_i),
    .pos_y_i   (pos_y_i),
    .heading_i (heading_i),
    .valid_o   (chain_v[0]),
    .ready_i   (chain_r[0]),
    .data_o    (chain_d[0])
  );

  assign in_stall_o = !front_ready;

  // row of CORDIC / square root cells
  for (genvar k = 0; k < NCell; k++) begin : g_cell
    ggs_cell #(
      .IDX   (k),
      .STEPS (Steps)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_v[k]),
      .ready_o (chain_r[k]),
      .data_i  (chain_d[k]),
      .valid_o (chain_v[k+1]),
      .ready_i (chain_r[k+1]),
      .data_o  (chain_d[k+1])
    );
  end

  // decision and output register
  ggs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .valid_i        (chain_v[NCell]),
    .ready_o        (chain_r[NCell]),
    .data_i         (chain_d[NCell]),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .linear_speed_o (linear_speed_o),
    .turn_rate_o    (turn_rate_o)
  );

  // checks
  `GGS_ASSERT_IMP(a_one_command, out_valid_o, (linear_speed_o == '0) || (turn_rate_o == '0))
  `GGS_ASSERT_IMP(a_speed_cap, out_valid_o, linear_speed_o <= cfg_q.max_speed)
  `GGS_ASSERT_IMP(a_turn_above_lim, out_valid_o && (turn_rate_o != '0), turn_rate_o > 15'd819)
  `GGS_ASSERT_IMP(a_stall_only_full, in_stall_o, out_valid_o && out_stall_i)
  `GGS_ASSERT_NXT(a_gain_write, cfg_valid_i && (cfg_index_i == CFG_GAIN), cfg_q.gain == $past(cfg_data_i[11:0]))

endmodule

`default_nettype wire

>>> hw/rtl/ggs_cell.sv
// One cell of the row: a CORDIC vectoring step, a square root digit, or both, as IDX selects.
// Depends on ggs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ggs_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned STEPS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  ggs_pkg::item_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output ggs_pkg::item_t data_o
);
  import ggs_pkg::*;

  localparam bit DoRot  = (IDX < STEPS);
  localparam bit DoSqrt = (IDX < SQRT_DIGITS);
  localparam logic signed [Z_W-1:0] Atan = atan_q20(IDX);

  logic   valid_q;
  item_t  data_q, data_d;

  logic signed [XY_W-1:0] x_in, y_in, xs, ys;
  logic [R_W+1:0]         rs, trial;

  // rotation and digit recurrence
  always_comb begin
    data_d = data_i;
    x_in   = data_i.x;
    y_in   = data_i.y;
    xs     = x_in >>> IDX;
    ys     = y_in >>> IDX;
    rs     = {data_i.r, data_i.n[N_W-1 -: 2]};
    trial  = {1'b0, data_i.q, 2'b01};
    if (DoRot) begin
      if (y_in > 0) begin
        data_d.x = x_in + ys;
        data_d.y = y_in - xs;
        data_d.z = data_i.z + Atan;
      end else begin
        data_d.x = x_in - ys;
        data_d.y = y_in + xs;
        data_d.z = data_i.z - Atan;
      end
    end
    if (DoSqrt) begin
      data_d.n = {data_i.n[N_W-3:0], 2'b00};
      if (rs >= trial) begin
        data_d.r = R_W'(rs - trial);
        data_d.q = {data_i.q[Q_W-2:0], 1'b1};
      end else begin
        data_d.r = rs[R_W-1:0];
        data_d.q = {data_i.q[Q_W-2:0], 1'b0};
      end
    end
  end

  // stage register; moves on whenever the next stage can take the beat
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

>>> hw/rtl/ggs_front.sv
// Front stages: goal offset, squares and quadrant fold, squared distance.
// Depends on ggs_pkg; feeds the first ggs_cell.
`timescale 1ns / 1ps
`default_nettype none

module ggs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ggs_pkg::cfg_t      cfg_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [14:0] heading_i,
  output logic               valid_o,
  input  logic               ready_i,
  output ggs_pkg::item_t     data_o
);
  import ggs_pkg::*;

  logic v0_q, v1_q, v2_q;
  logic r0, r1, r2;

  // stage 0: offset to the goal
  logic signed [16:0] dx_q, dy_q;
  logic signed [14:0] hd0_q;
  // stage 1: squares and folded start vector
  logic [31:0]            sqx_q, sqy_q;
  logic signed [XY_W-1:0] x1_q, y1_q;
  logic signed [Z_W-1:0]  z1_q;
  logic signed [14:0]     hd1_q;
  // stage 2: item for the cell row
  item_t data_q;

  logic signed [33:0] sqx_full, sqy_full;
  logic signed [17:0] fx, fy;
  logic signed [Z_W-1:0] fz;
  logic [32:0] d2;

  assign r2 = !v2_q || ready_i;
  assign r1 = !v1_q || r2;
  assign r0 = !v0_q || r1;
  assign ready_o = r0;

  // fold the vector into the right half plane by a quarter turn
  always_comb begin
    sqx_full = dx_q * dx_q;
    sqy_full = dy_q * dy_q;
    if (dx_q < 0) begin
      if (dy_q >= 0) begin
        fx = {dy_q[16], dy_q};
        fy = -{dx_q[16], dx_q};
        fz = HALF_PI_Q20;
      end else begin
        fx = -{dy_q[16], dy_q};
        fy = {dx_q[16], dx_q};
        fz = -HALF_PI_Q20;
      end
    end else begin
      fx = {dx_q[16], dx_q};
      fy = {dy_q[16], dy_q};
      fz = '0;
    end
  end

  assign d2 = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (r0) v0_q <= valid_i;
      if (r1) v1_q <= v0_q;
      if (r2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && r0) begin
      dx_q  <= {cfg_i.target_x[15], cfg_i.target_x} - {pos_x_i[15], pos_x_i};
      dy_q  <= {cfg_i.target_y[15], cfg_i.target_y} - {pos_y_i[15], pos_y_i};
      hd0_q <= heading_i;
    end
    if (v0_q && r1) begin
      sqx_q <= sqx_full[31:0];
      sqy_q <= sqy_full[31:0];
      x1_q  <= {{2{fx[17]}}, fx, 8'b0};
      y1_q  <= {{2{fy[17]}}, fy, 8'b0};
      z1_q  <= fz;
      hd1_q <= hd0_q;
    end
    if (v1_q && r2) begin
      data_q.x   <= x1_q;
      data_q.y   <= y1_q;
      data_q.z   <= z1_q;
      data_q.n   <= {1'b0, d2};
      data_q.q   <= '0;
      data_q.r   <= '0;
      data_q.hd  <= hd1_q;
      data_q.far <= ({1'b0, d2} > NEAR_D2);
    end
  end

  assign valid_o = v2_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

>>> hw/rtl/ggs_back.sv
// Back stages: heading error, branch choice, speed product and output register.
// Depends on ggs_pkg; takes the last ggs_cell's beat.
`timescale 1ns / 1ps
`default_nettype none

module ggs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ggs_pkg::cfg_t  cfg_i,
  input  logic           valid_i,
  output logic           ready_o,
  input  ggs_pkg::item_t data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [15:0]    linear_speed_o,
  output logic [14:0]    turn_rate_o
);
  import ggs_pkg::*;

  logic v1_q, out_valid_q;
  logic r1, r2;

  logic        turn_q, drive_q;
  logic [14:0] aerr_q;
  logic [28:0] prod_q;
  logic [15:0] lin_q;
  logic [14:0] turn_rate_q;

  logic signed [Z_W:0]  zr;
  logic signed [16:0]   brg;
  logic signed [17:0]   err;
  logic [17:0]          aerr;
  logic                 turn;
  logic [20:0]          lin_full;
  logic [15:0]          lin_cap;

  assign r2 = !out_valid_q || !out_stall_i;
  assign r1 = !v1_q || r2;
  assign ready_o = r1;

  // bearing rounded to rad * 4096, then the unwrapped heading error
  always_comb begin
    zr   = {data_i.z[Z_W-1], data_i.z} + 25'sd128;
    brg  = zr[Z_W:8];
    err  = {brg[16], brg} - {{3{data_i.hd[14]}}, data_i.hd};
    aerr = err[17] ? 18'(-err) : 18'(err);
    turn = data_i.far && (aerr > TURN_LIM);
  end

  // speed cap
  assign lin_full = prod_q[28:8];
  assign lin_cap  = (lin_full > {5'b0, cfg_i.max_speed}) ? cfg_i.max_speed : lin_full[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (r1) v1_q <= valid_i;
      if (r2) out_valid_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && r1) begin
      turn_q  <= turn;
      drive_q <= data_i.far && !turn;
      aerr_q  <= aerr[14:0];
      prod_q  <= {17'b0, cfg_i.gain} * {12'b0, data_i.q};
    end
    if (v1_q && r2) begin
      lin_q       <= drive_q ? lin_cap : '0;
      turn_rate_q <= turn_q ? aerr_q : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign linear_speed_o = lin_q;
  assign turn_rate_o    = turn_rate_q;

endmodule

`default_nettype wire
